FILE: rtl/pmdq_pkg.sv
// Shared types and constants for the partitioned multi-deque.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pmdq_pkg;

  localparam int NUM_QUEUES_DEF      = 4;
  localparam int SLOTS_PER_QUEUE_DEF = 8;
  localparam int DATA_WIDTH_DEF      = 32;

  localparam int FUNC_W = 2;
  localparam int QSEL_W = 2;
  localparam int ITEM_W = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 4;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_REAR   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    status_e status;
    logic    wr_en;
    logic    front_hit;
    logic    rear_hit;
    logic    empty;
    logic    full;
  } flags_t;

endpackage

FILE: rtl/pmdq_store.sv
// Slot store: one write port, two registered read ports.
// Depends on pmdq_pkg for default sizes only.
`timescale 1ns / 1ps

module pmdq_store #(
  parameter int DEPTH      = pmdq_pkg::NUM_QUEUES_DEF * pmdq_pkg::SLOTS_PER_QUEUE_DEF,
  parameter int DATA_WIDTH = pmdq_pkg::DATA_WIDTH_DEF,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [DATA_WIDTH-1:0] wr_data_i,
  input  logic                  rd_en_i,
  input  logic [AW-1:0]         rd_addr_a_i,
  input  logic [AW-1:0]         rd_addr_b_i,
  output logic [DATA_WIDTH-1:0] rd_data_a_o,
  output logic [DATA_WIDTH-1:0] rd_data_b_o
);
  import pmdq_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_a_q;
  logic [DATA_WIDTH-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem[rd_addr_a_i];
      rd_b_q <= mem[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

FILE: rtl/pmdq_ctrl.sv
// Per-queue front/rear/count registers and the operation decode.
// Depends on pmdq_pkg (func_e, status_e, flags_t).
`timescale 1ns / 1ps

module pmdq_ctrl #(
  parameter int NUM_QUEUES      = pmdq_pkg::NUM_QUEUES_DEF,
  parameter int SLOTS_PER_QUEUE = pmdq_pkg::SLOTS_PER_QUEUE_DEF,
  parameter int AW              = $clog2(NUM_QUEUES * SLOTS_PER_QUEUE)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        commit_i,
  input  logic [pmdq_pkg::FUNC_W-1:0] func_i,
  input  logic [pmdq_pkg::QSEL_W-1:0] qsel_i,
  output pmdq_pkg::flags_t            flags_o,
  output logic [pmdq_pkg::OCC_W-1:0]  occupancy_o,
  output logic [AW-1:0]               wr_addr_o,
  output logic [AW-1:0]               front_addr_o,
  output logic [AW-1:0]               rear_addr_o
);
  import pmdq_pkg::*;

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW = $clog2(SLOTS_PER_QUEUE);
  localparam int CW = $clog2(SLOTS_PER_QUEUE + 1);
  localparam logic [PW-1:0] LAST_OFF = PW'(SLOTS_PER_QUEUE - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS_PER_QUEUE);

  logic [PW-1:0] front_q [NUM_QUEUES];
  logic [PW-1:0] rear_q  [NUM_QUEUES];
  logic [CW-1:0] count_q [NUM_QUEUES];

  logic [QW-1:0] q_idx;
  logic [PW-1:0] cur_f, cur_r, front_d, rear_d, wr_off;
  logic [CW-1:0] cur_n, count_d;
  logic          wr_en;
  status_e       status;
  logic [AW-1:0] base;

  always_comb begin
    logic [QSEL_W-1:0] qs;
    qs = qsel_i;
    for (int i = 0; i < 3; i++) begin
      if (int'(qs) >= NUM_QUEUES) begin
        qs = qs - QSEL_W'(NUM_QUEUES);
      end
    end
    q_idx = QW'(qs);
  end

  assign cur_f = front_q[q_idx];
  assign cur_r = rear_q[q_idx];
  assign cur_n = count_q[q_idx];

  always_comb begin
    front_d = cur_f;
    rear_d  = cur_r;
    count_d = cur_n;
    wr_en   = 1'b0;
    wr_off  = '0;
    status  = ST_DONE;
    case (func_e'(func_i))
      OP_PUSH_REAR, OP_PUSH_FRONT: begin
        if (cur_n == FULL_CNT) begin
          status = ST_OVERFLOW;
        end else if (cur_n == '0) begin
          front_d = '0;
          rear_d  = '0;
          count_d = CW'(1);
          wr_en   = 1'b1;
        end else begin
          wr_en   = 1'b1;
          count_d = cur_n + CW'(1);
          if (func_e'(func_i) == OP_PUSH_REAR) begin
            rear_d = (cur_r == LAST_OFF) ? '0 : cur_r + PW'(1);
            wr_off = rear_d;
          end else begin
            front_d = (cur_f == '0) ? LAST_OFF : cur_f - PW'(1);
            wr_off  = front_d;
          end
        end
      end
      OP_POP_REAR, OP_POP_FRONT: begin
        if (cur_n == '0) begin
          status = ST_UNDERFLOW;
        end else if (cur_n == CW'(1)) begin
          front_d = '0;
          rear_d  = '0;
          count_d = '0;
        end else begin
          count_d = cur_n - CW'(1);
          if (func_e'(func_i) == OP_POP_REAR) begin
            rear_d = (cur_r == '0) ? LAST_OFF : cur_r - PW'(1);
          end else begin
            front_d = (cur_f == LAST_OFF) ? '0 : cur_f + PW'(1);
          end
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        front_q[i] <= '0;
        rear_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else if (commit_i) begin
      front_q[q_idx] <= front_d;
      rear_q[q_idx]  <= rear_d;
      count_q[q_idx] <= count_d;
    end
  end

  assign base = AW'(AW'(q_idx) * AW'(SLOTS_PER_QUEUE));

  assign wr_addr_o    = base + AW'(wr_off);
  assign front_addr_o = base + AW'(front_d);
  assign rear_addr_o  = base + AW'(rear_d);
  assign occupancy_o  = OCC_W'(count_d);

  assign flags_o.status    = status;
  assign flags_o.wr_en     = wr_en;
  assign flags_o.front_hit = wr_en && (wr_off == front_d);
  assign flags_o.rear_hit  = wr_en && (wr_off == rear_d);
  assign flags_o.empty     = (count_d == '0);
  assign flags_o.full      = (count_d == FULL_CNT);

endmodule

FILE: rtl/partitioned_multi_deque.sv
// Usage notes
// Top level of the partitioned multi-deque: input and result registers around
// the pointer control (pmdq_ctrl) and the slot store (pmdq_store); uses pmdq_pkg.
// Input channel: in_valid_i/in_ready_o carry func_i (push rear, push front,
// pop rear, pop front), queue_select_i and item_value_i (ignored for pops).
// Result channel: out_valid_o/out_ready_i carry the status (done, overflow,
// underflow) and the queue's front and rear values, empty and full flags and
// occupancy after the operation; values read as zero on an empty queue.
// queue_select_i is taken modulo NUM_QUEUES.
// Each operation passes the input register, then the result register.
// Throughput: one operation per cycle unless the result channel stalls; the
// pointer update and the store write of one operation complete in the cycle it
// moves to the result register, so the next operation sees them without waiting.
// Stall: while a result waits, one more operation is held in the input
// register; in_ready_o drops once both are occupied.
// Reset: all queues empty, pointers at offset zero, both registers empty; no
// clearing pass, store slots are only used after being written.
`timescale 1ns / 1ps

module partitioned_multi_deque #(
  parameter int NUM_QUEUES      = pmdq_pkg::NUM_QUEUES_DEF,
  parameter int SLOTS_PER_QUEUE = pmdq_pkg::SLOTS_PER_QUEUE_DEF,
  parameter int DATA_WIDTH      = pmdq_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [pmdq_pkg::FUNC_W-1:0]        func_i,
  input  logic [pmdq_pkg::QSEL_W-1:0]        queue_select_i,
  input  logic signed [pmdq_pkg::ITEM_W-1:0] item_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [pmdq_pkg::STAT_W-1:0]        status_o,
  output logic signed [pmdq_pkg::ITEM_W-1:0] front_value_o,
  output logic signed [pmdq_pkg::ITEM_W-1:0] rear_value_o,
  output logic                               queue_empty_o,
  output logic                               queue_full_o,
  output logic [pmdq_pkg::OCC_W-1:0]         occupancy_o
);
  import pmdq_pkg::*;

  localparam int DEPTH = NUM_QUEUES * SLOTS_PER_QUEUE;
  localparam int AW    = $clog2(DEPTH);

  logic                     a_valid_q;
  logic [FUNC_W-1:0]        a_func_q;
  logic [QSEL_W-1:0]        a_qsel_q;
  logic signed [ITEM_W-1:0] a_val_q;

  logic                     out_valid_q;
  flags_t                   flags_q;
  logic [OCC_W-1:0]         occ_q;
  logic signed [ITEM_W-1:0] byp_q;

  logic                         advance;
  logic                         res_free;
  flags_t                       flags_d;
  logic [OCC_W-1:0]             occ_d;
  logic [AW-1:0]                wr_addr, front_addr, rear_addr;
  logic signed [DATA_WIDTH-1:0] wr_data;
  logic signed [DATA_WIDTH-1:0] rd_front, rd_rear;

  assign res_free   = !out_valid_q || out_ready_i;
  assign advance    = a_valid_q && res_free;
  assign in_ready_o = !a_valid_q || res_free;
  assign wr_data    = DATA_WIDTH'(a_val_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_func_q <= func_i;
      a_qsel_q <= queue_select_i;
      a_val_q  <= item_value_i;
    end
  end

  pmdq_ctrl #(
    .NUM_QUEUES      (NUM_QUEUES),
    .SLOTS_PER_QUEUE (SLOTS_PER_QUEUE),
    .AW              (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .commit_i     (advance),
    .func_i       (a_func_q),
    .qsel_i       (a_qsel_q),
    .flags_o      (flags_d),
    .occupancy_o  (occ_d),
    .wr_addr_o    (wr_addr),
    .front_addr_o (front_addr),
    .rear_addr_o  (rear_addr)
  );

  pmdq_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_store (
    .clk_i       (clk_i),
    .we_i        (advance && flags_d.wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_en_i     (advance),
    .rd_addr_a_i (front_addr),
    .rd_addr_b_i (rear_addr),
    .rd_data_a_o (rd_front),
    .rd_data_b_o (rd_rear)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      flags_q <= flags_d;
      occ_q   <= occ_d;
      byp_q   <= ITEM_W'(wr_data);
    end
  end

  // a slot written by this transfer is taken from the bypass, not the store
  assign out_valid_o   = out_valid_q;
  assign status_o      = flags_q.status;
  assign queue_empty_o = flags_q.empty;
  assign queue_full_o  = flags_q.full;
  assign occupancy_o   = occ_q;
  assign front_value_o = flags_q.empty     ? '0    :
                         flags_q.front_hit ? byp_q : ITEM_W'(rd_front);
  assign rear_value_o  = flags_q.empty     ? '0    :
                         flags_q.rear_hit  ? byp_q : ITEM_W'(rd_rear);

`ifndef SYNTH
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(queue_full_o && queue_empty_o))
    else $error("queue reported both full and empty");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OVERFLOW) |-> queue_full_o)
    else $error("overflow on a queue that is not full");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_UNDERFLOW) |-> queue_empty_o)
    else $error("underflow on a queue that is not empty");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(occupancy_o) <= SLOTS_PER_QUEUE || SLOTS_PER_QUEUE > 15))
    else $error("occupancy beyond partition size");
`endif

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for partitioned_multi_deque (directed and random transfers).
// Keeps its own deque state to predict every result; depends on rtl/pmdq_pkg.sv and the DUT.

module tb_top;
  import pmdq_pkg::*;

  localparam int NQ           = NUM_QUEUES_DEF;
  localparam int SLOTS        = SLOTS_PER_QUEUE_DEF;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1725;
  localparam int QUIET_TAIL   = 250;

  typedef struct {
    status_e                  status;
    logic signed [ITEM_W-1:0] front_val;
    logic signed [ITEM_W-1:0] rear_val;
    logic                     empty;
    logic                     full;
    logic [OCC_W-1:0]         occ;
  } deque_result_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic [FUNC_W-1:0]        func_i         = OP_PUSH_REAR;
  logic [QSEL_W-1:0]        queue_select_i = '0;
  logic signed [ITEM_W-1:0] item_value_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b1;
  logic [STAT_W-1:0]        status_o;
  logic signed [ITEM_W-1:0] front_value_o;
  logic signed [ITEM_W-1:0] rear_value_o;
  logic                     queue_empty_o;
  logic                     queue_full_o;
  logic [OCC_W-1:0]         occupancy_o;

  // deque state mirror
  logic signed [ITEM_W-1:0] slot_mem [NQ][SLOTS];
  int                       head_ofs [NQ];
  int                       tail_ofs [NQ];
  int                       fill_cnt [NQ];
  deque_result_t            pending_results [$];
  deque_result_t            want_r;

  int  mismatch_cnt = 0;
  int  cycle_cnt    = 0;
  int  stall_left   = 0;
  bit  idle_en      = 1'b0;

  partitioned_multi_deque DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .queue_select_i (queue_select_i),
    .item_value_i   (item_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .front_value_o  (front_value_o),
    .rear_value_o   (rear_value_o),
    .queue_empty_o  (queue_empty_o),
    .queue_full_o   (queue_full_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result-side stalls
  always @(posedge clk_i) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_left  <= $urandom_range(1, 14);
      out_ready_i <= 1'b0;
    end else begin
      stall_left  <= 0;
      out_ready_i <= 1'b1;
    end
  end

  function automatic void apply_deque_op(func_e op, int q, logic signed [ITEM_W-1:0] v);
    deque_result_t r;
    int            n;
    r.status = ST_DONE;
    n = fill_cnt[q];
    if (op == OP_PUSH_REAR || op == OP_PUSH_FRONT) begin
      if (n >= SLOTS) begin
        r.status = ST_OVERFLOW;
      end else if (n == 0) begin
        head_ofs[q]    = 0;
        tail_ofs[q]    = 0;
        slot_mem[q][0] = v;
        fill_cnt[q]    = 1;
      end else if (op == OP_PUSH_REAR) begin
        tail_ofs[q]              = (tail_ofs[q] + 1) % SLOTS;
        slot_mem[q][tail_ofs[q]] = v;
        fill_cnt[q]              = n + 1;
      end else begin
        head_ofs[q]              = (head_ofs[q] + SLOTS - 1) % SLOTS;
        slot_mem[q][head_ofs[q]] = v;
        fill_cnt[q]              = n + 1;
      end
    end else begin
      if (n == 0) begin
        r.status = ST_UNDERFLOW;
      end else if (n == 1) begin
        head_ofs[q] = 0;
        tail_ofs[q] = 0;
        fill_cnt[q] = 0;
      end else begin
        if (op == OP_POP_REAR) tail_ofs[q] = (tail_ofs[q] + SLOTS - 1) % SLOTS;
        else head_ofs[q] = (head_ofs[q] + 1) % SLOTS;
        fill_cnt[q] = n - 1;
      end
    end
    n = fill_cnt[q];
    r.front_val = (n != 0) ? slot_mem[q][head_ofs[q]] : '0;
    r.rear_val  = (n != 0) ? slot_mem[q][tail_ofs[q]] : '0;
    r.empty     = (n == 0);
    r.full      = (n >= SLOTS);
    r.occ       = OCC_W'(n);
    pending_results.push_back(r);
  endfunction

  function automatic logic signed [ITEM_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return (32'sh1 << $urandom_range(0, 31));
      3: return ~(32'sh1 << $urandom_range(0, 31));
      4: return $urandom_range(0, 1) ? 32'sh0 : -32'sh1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(func_e op, logic [QSEL_W-1:0] qsel, logic signed [ITEM_W-1:0] v);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= op;
    queue_select_i <= qsel;
    item_value_i   <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_deque_op(op, int'(qsel) % NQ, v);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result transfer at cycle %0d", cycle_cnt);
      end else begin
        want_r = pending_results.pop_front();
        if (status_o !== want_r.status || front_value_o !== want_r.front_val ||
            rear_value_o !== want_r.rear_val || queue_empty_o !== want_r.empty ||
            queue_full_o !== want_r.full || occupancy_o !== want_r.occ) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch at cycle %0d: exp st=%0d f=%0d r=%0d e=%b fu=%b n=%0d",
                     cycle_cnt, want_r.status, want_r.front_val, want_r.rear_val,
                     want_r.empty, want_r.full, want_r.occ);
            $display("                     got st=%0d f=%0d r=%0d e=%b fu=%b n=%0d",
                     status_o, front_value_o, rear_value_o, queue_empty_o,
                     queue_full_o, occupancy_o);
          end
        end
      end
    end
  end

  task automatic test_underflow_on_empty();
    send_op(OP_POP_FRONT, 2'd0, 32'sh0);
    send_op(OP_POP_REAR, 2'd3, 32'sh5A5A_5A5A);
  endtask

  task automatic test_single_entry();
    send_op(OP_PUSH_FRONT, 2'd1, 32'sh7FFF_FFFF);
    send_op(OP_POP_REAR, 2'd1, 32'sh0);
    send_op(OP_PUSH_REAR, 2'd1, 32'sh8000_0000);
    send_op(OP_POP_FRONT, 2'd1, -32'sh1);
  endtask

  // the front pointer wraps, then overflow from either end
  task automatic test_fill_and_overflow();
    send_op(OP_PUSH_REAR, 2'd2, 32'sh0);
    send_op(OP_PUSH_FRONT, 2'd2, -32'sh1);
    for (int k = 0; k < SLOTS - 2; k++) begin
      send_op((k % 2) ? OP_PUSH_REAR : OP_PUSH_FRONT, 2'd2, pick_value());
    end
    send_op(OP_PUSH_REAR, 2'd2, 32'sh1234_5678);
    send_op(OP_PUSH_FRONT, 2'd2, 32'sh7FFF_FFFF);
  endtask

  task automatic test_drain_both_ends();
    for (int k = 0; k < SLOTS; k++) begin
      send_op((k % 2) ? OP_POP_FRONT : OP_POP_REAR, 2'd2, pick_value());
    end
    send_op(OP_POP_FRONT, 2'd2, 32'sh0);
  endtask

  task automatic test_random_traffic(int n_items);
    bit               fill_mode [NQ];
    logic [QSEL_W-1:0] qsel;
    int               q;
    bit               do_push;
    foreach (fill_mode[k]) fill_mode[k] = 1'($urandom_range(0, 1));
    qsel = '0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 150 == 0) idle_en = (n_items - i > QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      if (i == n_items / 2) wait_results_drained();
      if ($urandom_range(0, 2) != 0) qsel = QSEL_W'($urandom_range(0, NQ - 1));
      q = int'(qsel);
      if ($urandom_range(0, 24) == 0) fill_mode[q] = !fill_mode[q];
      do_push = fill_mode[q] ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
      if (do_push) send_op($urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT, qsel, pick_value());
      else send_op($urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT, qsel, pick_value());
    end
  endtask

  initial begin
    foreach (fill_cnt[k]) begin
      fill_cnt[k] = 0;
      head_ofs[k] = 0;
      tail_ofs[k] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_en = 1'b1;
    test_underflow_on_empty();
    test_single_entry();
    test_fill_and_overflow();
    test_drain_both_ends();
    wait_results_drained();
    test_random_traffic(RANDOM_ITEMS);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
